@@ src/swmm_pkg.sv @@
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants of the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample min_val;
        t_sample max_val;
    } t_extreme;

endpackage

@@ src/swmm_cell.sv @@
// ----------------------------------------------------------------------------
// swmm_cell
// One window cell: holds one stored sample in a shift line and folds it into
// the min/max token passing by while the token still has samples to cover.
// ----------------------------------------------------------------------------
module swmm_cell import swmm_pkg::*; #(
    parameter int REM_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  t_sample          i_data,
    output t_sample          o_data,
    input  logic             i_adv,
    input  logic             i_tok_valid,
    input  logic [REM_W-1:0] i_tok_rem,
    input  t_extreme         i_tok_ext,
    output logic             o_tok_valid,
    output logic [REM_W-1:0] o_tok_rem,
    output t_extreme         o_tok_ext
);

    t_sample          r_data;
    logic             r_tok_valid;
    logic [REM_W-1:0] r_tok_rem;
    t_extreme         r_tok_ext;
    logic [REM_W-1:0] n_tok_rem;
    t_extreme         n_tok_ext;

    always_comb begin
        n_tok_rem = i_tok_rem;
        n_tok_ext = i_tok_ext;
        if (i_tok_rem != '0) begin
            n_tok_rem = i_tok_rem - REM_W'(1);
            if (r_data < i_tok_ext.min_val) begin
                n_tok_ext.min_val = r_data;
            end
            if (r_data > i_tok_ext.max_val) begin
                n_tok_ext.max_val = r_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok_rem <= n_tok_rem;
            r_tok_ext <= n_tok_ext;
        end
    end

    assign o_data      = r_data;
    assign o_tok_valid = r_tok_valid;
    assign o_tok_rem   = r_tok_rem;
    assign o_tok_ext   = r_tok_ext;

endmodule

@@ src/sliding_window_min_max.sv @@
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Sliding window minimum and maximum over signed 32-bit samples, built as a
// shift line of WINDOW_MAX cells with a min/max token walking the line.
// ----------------------------------------------------------------------------
// Flow: a sample that yields a result launches a min/max token into the launch
// register; the token walks the cell chain, and the output register then takes
// the result. Such a sample holds off the next transfer until the token leaves
// the chain, longer while a held result stalls the token at the chain end; a
// sample that yields none does not hold off the next transfer. Synchronous
// active-low reset clears fill count, window length (to 1), tokens and output
// valid; stored samples are not reset.
// ----------------------------------------------------------------------------
module sliding_window_min_max import swmm_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_sample          i_sample,
    input  logic             i_restart,
    output logic             o_valid,
    input  logic             i_ready,
    output t_sample          o_window_min,
    output t_sample          o_window_max,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int MW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0] r_window_length;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    w_len;
    logic [MW-1:0]    w_wl_ext;
    logic             r_busy;
    logic             w_accept, w_produce, w_adv, w_take;

    logic             r_l_valid;
    logic [CW-1:0]    r_l_rem;
    t_extreme         r_l_ext;

    logic             r_out_valid;
    t_extreme         r_out;

    logic [WINDOW_MAX:0] w_tok_valid;
    logic [CW-1:0]       w_tok_rem [WINDOW_MAX+1];
    t_extreme            w_tok_ext [WINDOW_MAX+1];
    t_sample             w_data    [WINDOW_MAX];

    assign o_ready     = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !r_busy;
    assign w_take      = r_out_valid && i_ready;
    assign w_adv       = !(w_tok_valid[WINDOW_MAX] && r_out_valid && !i_ready);

    always_comb begin
        w_wl_ext = MW'(r_window_length);
        if (r_window_length == '0) begin
            w_len = CW'(1);
        end else if (w_wl_ext > MW'(WINDOW_MAX)) begin
            w_len = CW'(WINDOW_MAX);
        end else begin
            w_len = CW'(w_wl_ext);
        end
    end

    always_comb begin
        if (i_restart) begin
            n_fill = CW'(1);
        end else if (r_fill < CW'(WINDOW_MAX)) begin
            n_fill = r_fill + CW'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    assign w_produce = w_accept && (n_fill >= w_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= CFG_W'(1);
            r_fill          <= '0;
            r_busy          <= 1'b0;
            r_l_valid       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_length <= i_cfg_data;
            end
            if (w_accept) begin
                r_fill <= n_fill;
            end
            if (w_produce) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_tok_valid[WINDOW_MAX]) begin
                r_busy <= 1'b0;
            end
            if (w_produce) begin
                r_l_valid <= 1'b1;
            end else if (w_adv) begin
                r_l_valid <= 1'b0;
            end
            if (w_adv && w_tok_valid[WINDOW_MAX]) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_l_rem         <= w_len;
            r_l_ext.min_val <= i_sample;
            r_l_ext.max_val <= i_sample;
        end
        if (w_adv && w_tok_valid[WINDOW_MAX]) begin
            r_out <= w_tok_ext[WINDOW_MAX];
        end
    end

    assign w_tok_valid[0] = r_l_valid;
    assign w_tok_rem[0]   = r_l_rem;
    assign w_tok_ext[0]   = r_l_ext;
    assign w_data[0]      = i_sample;

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        if (k < WINDOW_MAX - 1) begin : g_mid
            swmm_cell #(.REM_W(CW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (w_accept),
                .i_data      (w_data[k]),
                .o_data      (w_data[k+1]),
                .i_adv       (w_adv),
                .i_tok_valid (w_tok_valid[k]),
                .i_tok_rem   (w_tok_rem[k]),
                .i_tok_ext   (w_tok_ext[k]),
                .o_tok_valid (w_tok_valid[k+1]),
                .o_tok_rem   (w_tok_rem[k+1]),
                .o_tok_ext   (w_tok_ext[k+1])
            );
        end else begin : g_last
            swmm_cell #(.REM_W(CW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (w_accept),
                .i_data      (w_data[k]),
                .o_data      (),
                .i_adv       (w_adv),
                .i_tok_valid (w_tok_valid[k]),
                .i_tok_rem   (w_tok_rem[k]),
                .i_tok_ext   (w_tok_ext[k]),
                .o_tok_valid (w_tok_valid[k+1]),
                .o_tok_rem   (w_tok_rem[k+1]),
                .o_tok_ext   (w_tok_ext[k+1])
            );
        end
    end

    assign o_valid      = r_out_valid;
    assign o_window_min = r_out.min_val;
    assign o_window_max = r_out.max_val;

`ifndef ASSERT_OFF
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one token in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_tok_valid == '0))
        else $error("token in flight while not busy");

    a_token_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_valid[WINDOW_MAX] |-> (w_tok_rem[WINDOW_MAX] == '0))
        else $error("token left the chain with samples uncovered");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.min_val <= r_out.max_val))
        else $error("result minimum above maximum");
`endif

endmodule
